### rtl/c_source_minifier_top_assert.svh
//------------------------------------------------------------------------------
// C source minifier assertion macros
// Shared concurrent-assertion forms, clocked on clk, disabled in reset.
//------------------------------------------------------------------------------
`ifndef C_SOURCE_MINIFIER_TOP_ASSERT_SVH
`define C_SOURCE_MINIFIER_TOP_ASSERT_SVH

// same-cycle implication
`define CMINF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CMINF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/cminf_pkg.sv
//------------------------------------------------------------------------------
// cminf_pkg
// Scanner mode codes, character codes and shared types of the minifier.
//------------------------------------------------------------------------------
package cminf_pkg;

  // scanner modes
  localparam logic [3:0] MODE_NORMAL     = 4'd0;
  localparam logic [3:0] MODE_SLASH      = 4'd1;
  localparam logic [3:0] MODE_BLOCK      = 4'd2;
  localparam logic [3:0] MODE_BLOCK_STAR = 4'd3;
  localparam logic [3:0] MODE_LITERAL    = 4'd4;
  localparam logic [3:0] MODE_ESCAPE     = 4'd5;
  localparam logic [3:0] MODE_LINE       = 4'd6;
  localparam logic [3:0] MODE_DIRECTIVE  = 4'd7;
  localparam logic [3:0] MODE_SPACE      = 4'd8;

  // characters
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_UPPER_L = 8'h4C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_COLON  = 8'h3A;

  // results produced by one source byte
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      cnt;
  } grp_t;

  // full outcome of one scan step
  typedef struct packed {
    logic [3:0] scan_mode;
    logic [3:0] prior_mode;
    logic [7:0] quote_byte;
    grp_t       grp;
  } step_t;

endpackage

### rtl/cminf_step.sv
//------------------------------------------------------------------------------
// cminf_step
// Combinational scan step: next mode, prior mode, remembered quote and emitted bytes.
//------------------------------------------------------------------------------
module cminf_step
  import cminf_pkg::*;
(
  input  logic       keep,
  input  logic [3:0] scan_mode,
  input  logic [3:0] prior_mode,
  input  logic [7:0] prior_byte,
  input  logic [7:0] quote_byte,
  input  logic [7:0] cur_byte,
  output step_t      step
);

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_name(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7A)) ||
           ((c >= 8'h41) && (c <= 8'h5A)) || (c == CH_UNDER);
  endfunction

  function automatic logic is_compound(input logic [7:0] p, input logic [7:0] c);
    logic r;
    r = 1'b0;
    if (c == CH_GT && p == CH_MINUS) r = 1'b1;
    else if (c == CH_EQ)
      r = (p == CH_LT) || (p == CH_GT) || (p == CH_BANG) || (p == CH_PLUS) ||
          (p == CH_MINUS) || (p == CH_STAR) || (p == CH_SLASH) || (p == CH_PIPE) ||
          (p == CH_AMP) || (p == CH_CARET) || (p == CH_PCT);
    return r;
  endfunction

  function automatic logic is_doubled_ok(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_PIPE) || (c == CH_AMP) ||
           (c == CH_COLON) || (c == CH_EQ) || (c == CH_LT) || (c == CH_GT) ||
           (c == CH_DOT);
  endfunction

  logic [2:0][7:0] em;
  logic [1:0]      cnt;
  logic [3:0]      nscan;
  logic [3:0]      left;
  logic [7:0]      nquote;
  logic            is_quote;
  logic            is_ws;
  logic            is_eol;
  logic            pn;
  logic            bn;

  always_comb begin
    em       = '0;
    cnt      = 2'd0;
    nscan    = scan_mode;
    left     = scan_mode;
    nquote   = quote_byte;
    is_quote = (cur_byte == CH_DQUOTE) || (cur_byte == CH_SQUOTE);
    is_eol   = (cur_byte == CH_LF) || (cur_byte == CH_CR);
    is_ws    = is_eol || (cur_byte == CH_TAB) || (cur_byte == CH_SPACE);
    pn       = is_name(prior_byte);
    bn       = is_name(cur_byte);

    case (scan_mode)
      MODE_NORMAL: begin
        if (cur_byte == CH_SLASH) begin
          nscan = MODE_SLASH;
        end else if (cur_byte == CH_HASH) begin
          if (keep) begin
            em[cnt] = CH_LF;    cnt = cnt + 2'd1;
            em[cnt] = cur_byte; cnt = cnt + 2'd1;
          end
          nscan = MODE_DIRECTIVE;
        end else if (is_quote) begin
          if (prior_mode != MODE_SPACE && prior_byte != CH_UPPER_L) begin
            em[cnt] = CH_SPACE; cnt = cnt + 2'd1;
          end
          em[cnt] = cur_byte; cnt = cnt + 2'd1;
          nscan  = MODE_LITERAL;
          nquote = cur_byte;
        end else if (cur_byte == CH_BSLASH) begin
          nscan = MODE_ESCAPE;
        end else if (is_ws) begin
          if (prior_mode != MODE_SPACE) begin
            em[cnt] = CH_SPACE; cnt = cnt + 2'd1;
          end
          left = MODE_SPACE;
        end else begin
          // token boundary spacing
          if (prior_mode != MODE_SPACE) begin
            if (pn != bn && !(is_digit(prior_byte) && cur_byte == CH_DOT) &&
                !(prior_byte == CH_DOT && is_digit(cur_byte))) begin
              em[cnt] = CH_SPACE; cnt = cnt + 2'd1;
            end
            if (!pn && !bn) begin
              if (prior_byte != cur_byte) begin
                if (!is_compound(prior_byte, cur_byte)) begin
                  em[cnt] = CH_SPACE; cnt = cnt + 2'd1;
                end
              end else if (!is_doubled_ok(cur_byte)) begin
                em[cnt] = CH_SPACE; cnt = cnt + 2'd1;
              end
            end
          end
          em[cnt] = cur_byte; cnt = cnt + 2'd1;
        end
      end
      MODE_SLASH: begin
        if (cur_byte == CH_SLASH) begin
          nscan = MODE_LINE;
        end else if (cur_byte == CH_STAR) begin
          nscan = MODE_BLOCK;
        end else if (cur_byte == CH_BSLASH) begin
          em[cnt] = CH_SLASH; cnt = cnt + 2'd1;
          left  = MODE_NORMAL;
          nscan = MODE_ESCAPE;
        end else if (cur_byte == CH_SPACE) begin
          em[cnt] = CH_SLASH; cnt = cnt + 2'd1;
          nscan = MODE_NORMAL;
        end else if (is_quote) begin
          em[cnt] = CH_SLASH; cnt = cnt + 2'd1;
          em[cnt] = cur_byte; cnt = cnt + 2'd1;
          nscan  = MODE_LITERAL;
          nquote = cur_byte;
        end else begin
          em[cnt] = CH_SLASH; cnt = cnt + 2'd1;
          if (cur_byte != CH_EQ) begin
            em[cnt] = CH_SPACE; cnt = cnt + 2'd1;
          end
          em[cnt] = cur_byte; cnt = cnt + 2'd1;
          nscan = MODE_NORMAL;
        end
      end
      MODE_BLOCK: begin
        if (cur_byte == CH_STAR) nscan = MODE_BLOCK_STAR;
      end
      MODE_BLOCK_STAR: begin
        if (cur_byte == CH_SLASH) begin
          nscan = MODE_NORMAL;
        end else if (cur_byte == CH_STAR) begin
          nscan = MODE_BLOCK_STAR;
        end else if (cur_byte == CH_BSLASH) begin
          left  = MODE_BLOCK;
          nscan = MODE_ESCAPE;
        end else begin
          nscan = MODE_BLOCK;
        end
      end
      MODE_LITERAL: begin
        if (is_quote) begin
          em[cnt] = cur_byte; cnt = cnt + 2'd1;
          if (cur_byte == quote_byte) nscan = MODE_NORMAL;
        end else if (cur_byte == CH_BSLASH) begin
          nscan = MODE_ESCAPE;
        end else begin
          em[cnt] = cur_byte; cnt = cnt + 2'd1;
        end
      end
      MODE_ESCAPE: begin
        // back to the mode the escape came from
        nscan = prior_mode;
        if (prior_mode == MODE_NORMAL || prior_mode == MODE_LITERAL ||
            (prior_mode == MODE_DIRECTIVE && keep)) begin
          em[cnt] = CH_BSLASH; cnt = cnt + 2'd1;
          em[cnt] = cur_byte;  cnt = cnt + 2'd1;
        end
      end
      MODE_LINE: begin
        if (is_eol) begin
          left  = MODE_SPACE;
          nscan = MODE_NORMAL;
        end
      end
      MODE_DIRECTIVE: begin
        if (cur_byte == CH_BSLASH) begin
          nscan = MODE_ESCAPE;
        end else if (is_eol) begin
          nscan = MODE_NORMAL;
          if (keep) begin
            em[cnt] = cur_byte; cnt = cnt + 2'd1;
            left = MODE_SPACE;
          end
        end else if (keep) begin
          em[cnt] = cur_byte; cnt = cnt + 2'd1;
        end
      end
      default: begin
      end
    endcase

    step.scan_mode  = nscan;
    step.prior_mode = left;
    step.quote_byte = nquote;
    step.grp.bytes  = em;
    step.grp.cnt    = cnt;
  end

endmodule

### rtl/cminf_ser.sv
//------------------------------------------------------------------------------
// cminf_ser
// Result register: holds one byte group and sends it out a byte per request.
//------------------------------------------------------------------------------
module cminf_ser
  import cminf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  grp_t       grp,
  output logic       free,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic [2:0][7:0] bytes_r;
  logic [1:0]      cnt_r;
  logic [1:0]      idx_r;
  logic            valid_r;
  logic            valid_nxt;
  logic [1:0]      idx_nxt;
  logic            send;

  assign send      = valid_r && !out_stall;
  assign out_valid = valid_r;
  assign out_last  = (idx_r == cnt_r - 2'd1);
  assign free      = !valid_r || (send && out_last);

  always_comb begin
    case (idx_r)
      2'd0:    out_byte = bytes_r[0];
      2'd1:    out_byte = bytes_r[1];
      2'd2:    out_byte = bytes_r[2];
      default: out_byte = bytes_r[0];
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = 2'd0;
    end else if (send) begin
      if (out_last) valid_nxt = 1'b0;
      else          idx_nxt   = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes_r <= grp.bytes;
      cnt_r   <= grp.cnt;
    end
  end

`include "c_source_minifier_top_assert.svh"

  `CMINF_ASSERT_NOW(a_ser_load_free, load, free && grp.cnt != 2'd0, "group load into busy register")
  `CMINF_ASSERT_NOW(a_ser_idx_range, valid_r, idx_r < cnt_r, "result index past group count")
  `CMINF_ASSERT_NEXT(a_ser_last_drains, send && out_last && !load, !valid_r, "group not released")

endmodule

### rtl/c_source_minifier_top.sv
//------------------------------------------------------------------------------
// c_source_minifier_top
// Streaming C source minifier, one source byte per request.
//------------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall carry source bytes (in_byte). out_valid/out_stall carry
//   minified bytes (out_byte); out_last marks the final byte produced for one
//   source byte. A source byte may produce no output at all.
//   cfg_valid/cfg_ready write keep_directives (cfg_keep_directives); cfg_ready
//   is always high. Write it only while the block is idle.
// Path: an accepted byte is held in the input register and scanned there;
//   its results are loaded into the result register, which drives out_byte.
// Throughput: one source byte per cycle while each byte yields at most one
//   result and out_stall is low. A byte with more results holds the result
//   register until all are sent, so the output port (one byte per cycle) sets the sustained rate.
// Stall: while out_stall holds a group, the next byte waits in the input
//   register and in_stall rises; bytes with no result still pass through.
// Reset (synchronous, rst_n low): scanner in normal code mode, prior byte and
//   quote zero, keep_directives cleared, both registers empty.
//------------------------------------------------------------------------------
module c_source_minifier_top
  import cminf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // source bytes
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  // minified bytes
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last,
  // keep_directives register
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_keep_directives
);

  // input register
  logic       item_valid_r;
  logic       item_valid_nxt;
  logic [7:0] item_byte_r;
  logic       in_take;

  // scanner state
  logic [3:0] scan_mode_r;
  logic [3:0] prior_mode_r;
  logic [7:0] prior_byte_r;
  logic [7:0] quote_byte_r;
  logic       keep_r;

  step_t      step;
  logic       grp_free;
  logic       consume;
  logic       load;

  assign cfg_ready = 1'b1;

  cminf_step u_step (
    .keep       (keep_r),
    .scan_mode  (scan_mode_r),
    .prior_mode (prior_mode_r),
    .prior_byte (prior_byte_r),
    .quote_byte (quote_byte_r),
    .cur_byte   (item_byte_r),
    .step       (step)
  );

  // a byte with no result never needs the result register
  assign consume  = item_valid_r && (grp_free || step.grp.cnt == 2'd0);
  assign load     = consume && step.grp.cnt != 2'd0;
  assign in_stall = item_valid_r && !consume;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    item_valid_nxt = item_valid_r;
    if (in_take)      item_valid_nxt = 1'b1;
    else if (consume) item_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      scan_mode_r  <= MODE_NORMAL;
      prior_mode_r <= MODE_NORMAL;
      prior_byte_r <= 8'd0;
      quote_byte_r <= 8'd0;
      keep_r       <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
      if (consume) begin
        scan_mode_r  <= step.scan_mode;
        prior_mode_r <= step.prior_mode;
        prior_byte_r <= item_byte_r;
        quote_byte_r <= step.quote_byte;
      end
      if (cfg_valid && cfg_ready) keep_r <= cfg_keep_directives;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) item_byte_r <= in_byte;
  end

  cminf_ser u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .grp       (step.grp),
    .free      (grp_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

`include "c_source_minifier_top_assert.svh"

  `CMINF_ASSERT_NOW(a_top_mode_live, 1'b1, scan_mode_r != MODE_SPACE, "space mode as scan mode")
  `CMINF_ASSERT_NEXT(a_top_hold_item, in_stall, item_valid_r && $stable(item_byte_r), "stalled byte lost")
  `CMINF_ASSERT_NEXT(a_top_prior_byte, consume, prior_byte_r == $past(item_byte_r), "prior byte not tracked")

endmodule
